@@ rtl/bqwt_pkg.sv @@
// Shared types and constants for the brace-quoted word tokenizer.
// No dependencies; every other file in rtl/ imports this package.
package bqwt_pkg;

  // Scanner phase.
  typedef enum logic [2:0] {
    PH_SKIP           = 3'd0,
    PH_SKIP_COMMENT   = 3'd1,
    PH_BRACED         = 3'd2,
    PH_BRACED_COMMENT = 3'd3,
    PH_WORD           = 3'd4,
    PH_ESC            = 3'd5,
    PH_HEX            = 3'd6,
    PH_OCT            = 3'd7
  } phase_t;

  // Result kind.
  typedef enum logic [1:0] {
    K_BYTE      = 2'd0,
    K_END_WORD  = 2'd1,
    K_END_INPUT = 2'd2,
    K_MISSING   = 2'd3
  } kind_t;

  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_X      = 8'h78;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic [15:0] line;
  } res_t;

  // All results caused by one accepted input item.
  typedef struct packed {
    logic [2:0]                  count;
    res_t [MAX_RESULTS-1:0]      res;
  } bundle_t;

endpackage

@@ rtl/bqwt_front.sv @@
// Front end of the tokenizer: accepts one byte per cycle while q_ready is
// high, runs the scanner FSM and turns each byte into a result bundle. Uses bqwt_pkg.
module bqwt_front
  import bqwt_pkg::*;
#(
  parameter int NEST_BITS = 8,
  parameter int LINE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] byte_in,
  input  logic       end_of_input,
  input  logic       brace_as_token,
  input  logic       q_ready,
  output logic       in_ready,
  output logic       push,
  output bundle_t    bundle
);

  typedef struct packed {
    phase_t               phase;
    logic                 esc_braces;
    logic [11:0]          esc_val;
    logic [1:0]           esc_cnt;
    logic [NEST_BITS-1:0] depth;
    logic [LINE_BITS-1:0] line;
  } scan_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } put_t;

  typedef struct packed {
    scan_t            s;
    logic             again;
    logic [1:0]       n;
    put_t [2:0]       puts;
  } pass_t;

  scan_t   state;
  scan_t   state_next;
  bundle_t bundle_next;
  logic    accept;

  function automatic logic [15:0] sat16(logic [LINE_BITS-1:0] l);
    logic [31:0] w;
    w = 32'(l);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic phase_t owner(scan_t s);
    return s.esc_braces ? PH_BRACED : PH_WORD;
  endfunction

  // One pass of the scanner over the current byte. A pass may ask for the
  // same byte to be looked at again in the new phase.
  function automatic pass_t do_pass(scan_t s_in, logic [7:0] c, logic eoi, logic bt);
    pass_t      p;
    logic [3:0] hd;
    logic       hv;
    logic [7:0] cv;
    logic       ch;
    logic [1:0] cnt;
    p       = '0;
    p.s     = s_in;
    hd      = 4'd0;
    hv      = 1'b0;
    cv      = 8'd0;
    ch      = 1'b1;
    cnt     = 2'd0;
    if (c >= "0" && c <= "9") begin
      hd = 4'(c - "0");
      hv = 1'b1;
    end else if (c >= "A" && c <= "F") begin
      hd = 4'(c - "A" + 8'd10);
      hv = 1'b1;
    end else if (c >= "a" && c <= "f") begin
      hd = 4'(c - "a" + 8'd10);
      hv = 1'b1;
    end
    case (c)
      "a":     cv = 8'd7;
      "b":     cv = 8'd8;
      "f":     cv = 8'd12;
      "n":     cv = 8'd10;
      "r":     cv = 8'd13;
      "t":     cv = 8'd9;
      "v":     cv = 8'd11;
      default: ch = 1'b0;
    endcase

    case (s_in.phase)
      PH_SKIP: begin
        if (eoi) begin
          p.puts[0] = '{K_END_INPUT, 8'd0}; p.n = 2'd1;
        end else if (c == CH_HASH) begin
          p.s.phase = PH_SKIP_COMMENT;
        end else if (c == CH_LF) begin
          if (p.s.line != '1) p.s.line = p.s.line + 1'b1;
        end else if (is_space(c)) begin
          p.s.phase = PH_SKIP;
        end else if (c == CH_LBRACE && !bt) begin
          p.s.phase = PH_BRACED;
          p.s.depth = '0;
        end else if (c == CH_LBRACE || c == CH_RBRACE) begin
          p.puts[0] = '{K_BYTE, c};
          p.puts[1] = '{K_END_WORD, 8'd0};
          p.n = 2'd2;
        end else begin
          p.s.phase = PH_WORD;
          p.again   = 1'b1;
        end
      end
      PH_SKIP_COMMENT, PH_BRACED_COMMENT: begin
        if (eoi || c == CH_LF) begin
          if (p.s.line != '1) p.s.line = p.s.line + 1'b1;
          p.s.phase = (s_in.phase == PH_SKIP_COMMENT) ? PH_SKIP : PH_BRACED;
          p.again   = eoi;
        end
      end
      PH_BRACED: begin
        if (eoi) begin
          p.puts[0] = '{K_MISSING, 8'd0};
          p.puts[1] = '{K_END_WORD, 8'd0};
          p.puts[2] = '{K_END_INPUT, 8'd0};
          p.n = 2'd3;
          p.s.phase = PH_SKIP;
        end else if (c == CH_HASH) begin
          p.s.phase = PH_BRACED_COMMENT;
        end else if (c == CH_BSLASH) begin
          p.s.esc_braces = 1'b1;
          p.s.phase      = PH_ESC;
        end else if (c == CH_RBRACE && s_in.depth == '0) begin
          p.puts[0] = '{K_END_WORD, 8'd0}; p.n = 2'd1;
          p.s.phase = PH_SKIP;
        end else begin
          if (c == CH_LF && p.s.line != '1) p.s.line = p.s.line + 1'b1;
          if (c == CH_LBRACE && s_in.depth != '1) p.s.depth = s_in.depth + 1'b1;
          if (c == CH_RBRACE) p.s.depth = s_in.depth - 1'b1;
          p.puts[0] = '{K_BYTE, c}; p.n = 2'd1;
        end
      end
      PH_WORD: begin
        if (eoi) begin
          p.puts[0] = '{K_END_WORD, 8'd0};
          p.puts[1] = '{K_END_INPUT, 8'd0};
          p.n = 2'd2;
          p.s.phase = PH_SKIP;
        end else if (c == CH_BSLASH) begin
          p.s.esc_braces = 1'b0;
          p.s.phase      = PH_ESC;
        end else if (is_space(c) || c == CH_LBRACE || c == CH_RBRACE || c == CH_HASH) begin
          p.puts[0] = '{K_END_WORD, 8'd0}; p.n = 2'd1;
          p.s.phase = PH_SKIP;
          p.again   = 1'b1;
        end else begin
          p.puts[0] = '{K_BYTE, c}; p.n = 2'd1;
        end
      end
      PH_ESC: begin
        if (eoi) begin
          p.s.phase = owner(s_in);
          p.again   = 1'b1;
        end else if (c == CH_LF) begin
          if (p.s.line != '1) p.s.line = p.s.line + 1'b1;
          if (s_in.esc_braces) begin
            p.s.phase = PH_BRACED;
          end else begin
            p.puts[0] = '{K_END_WORD, 8'd0}; p.n = 2'd1;
            p.s.phase = PH_SKIP;
          end
        end else if (ch) begin
          p.puts[0] = '{K_BYTE, cv}; p.n = 2'd1;
          p.s.phase = owner(s_in);
        end else if (c == CH_X) begin
          p.s.esc_val = 12'd0;
          p.s.esc_cnt = 2'd0;
          p.s.phase   = PH_HEX;
        end else if (c >= "0" && c <= "7") begin
          p.s.esc_val = 12'(c - "0");
          p.s.esc_cnt = 2'd0;
          p.s.phase   = PH_OCT;
        end else begin
          p.puts[0] = '{K_BYTE, c}; p.n = 2'd1;
          p.s.phase = owner(s_in);
        end
      end
      PH_HEX, PH_OCT: begin
        if (!eoi && ((s_in.phase == PH_HEX && hv) ||
                     (s_in.phase == PH_OCT && c >= "0" && c <= "7"))) begin
          if (s_in.phase == PH_HEX) p.s.esc_val = {s_in.esc_val[7:0], hd};
          else p.s.esc_val = {s_in.esc_val[8:0], c[2:0]};
          cnt = s_in.esc_cnt + 2'd1;
          p.s.esc_cnt = cnt;
          if ((s_in.phase == PH_HEX && cnt == 2'd3) ||
              (s_in.phase == PH_OCT && cnt >= 2'd2)) begin
            p.puts[0] = '{K_BYTE, p.s.esc_val[7:0]}; p.n = 2'd1;
            p.s.phase = owner(s_in);
          end
        end else begin
          p.puts[0] = '{K_BYTE, s_in.esc_val[7:0]}; p.n = 2'd1;
          p.s.phase = owner(s_in);
          p.again   = 1'b1;
        end
      end
      default: p.s = s_in;
    endcase
    return p;
  endfunction

  // At most six passes settle one byte; their results are packed in order.
  always_comb begin
    scan_t      s;
    pass_t      pr;
    logic       again;
    logic [2:0] rcount;
    s           = state;
    pr          = '0;
    again       = 1'b1;
    rcount      = 3'd0;
    bundle_next = '0;
    for (int p = 0; p < 6; p++) begin
      if (again) begin
        pr    = do_pass(s, byte_in, end_of_input, brace_as_token);
        s     = pr.s;
        again = pr.again;
        for (int j = 0; j < 3; j++) begin
          if (2'(j) < pr.n && rcount < 3'(MAX_RESULTS)) begin
            bundle_next.res[rcount[1:0]] = '{pr.puts[j].kind, pr.puts[j].value,
                                              sat16(s.line)};
            rcount = rcount + 3'd1;
          end
        end
      end
    end
    bundle_next.count = rcount;
    state_next        = s;
  end

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (bundle_next.count != 3'd0);
  assign bundle   = bundle_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= PH_SKIP;
      state.esc_braces <= 1'b0;
      state.esc_val    <= 12'd0;
      state.esc_cnt    <= 2'd0;
      state.depth      <= '0;
      state.line       <= LINE_BITS'(1);
    end else if (accept) begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/bqwt_queue.sv @@
// Short queue of result bundles between the scanner and the output stage.
// Uses bqwt_pkg for the bundle type and depth.
module bqwt_queue
  import bqwt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    ready,
  input  logic    pop,
  output logic    valid,
  output bundle_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  bundle_t        slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    fill;
  logic           do_push;
  logic           do_pop;

  assign ready   = (fill != (PW+1)'(QUEUE_DEPTH));
  assign valid   = (fill != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

endmodule

@@ rtl/bqwt_back.sv @@
// Output stage: holds one bundle and sends its results one per cycle while out_ready is high.
// Uses bqwt_pkg for the bundle and result types.
module bqwt_back
  import bqwt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  bundle_t q_head,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_res,
  output logic    out_last
);

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       take;
  logic       load;

  assign out_valid = cur_valid;
  assign out_res   = cur.res[idx];
  assign out_last  = ({1'b0, idx} == cur.count - 3'd1);
  assign take      = cur_valid && out_ready;
  assign load      = q_valid && (!cur_valid || (take && out_last));
  assign q_pop     = load;

  always_ff @(posedge clk) begin
    if (load) cur <= q_head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (take) begin
      if (out_last) cur_valid <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

endmodule

@@ rtl/brace_quoted_word_tokenizer_core.sv @@
// Top level of the brace-quoted word tokenizer.
// Uses bqwt_pkg, bqwt_front, bqwt_queue and bqwt_back.
//
// The core reads a text stream one byte per request and splits it into words:
// unquoted runs, single brace tokens, and brace-quoted text with nesting.
// Whitespace and hash comments between words are dropped, and backslash
// escapes (control letters, hex, octal, literal) are decoded to one byte.
// Each input request yields zero to four results; every result carries the
// current line number, and the final result of a request has tlast set.
// The scanner takes one input request per clock cycle as long as its result
// queue (four entries, one entry per request that produced results) has room.
// Results leave one per cycle while m_axis_tready is high, so sustained input
// rate is one byte per cycle for text that yields at most one result per byte
// and an accepting output, and is set by the single output port otherwise.
// Input and output stall independently.
module brace_quoted_word_tokenizer_core
  import bqwt_pkg::*;
#(
  parameter int NEST_BITS = 8,
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,   // end_of_input
  input  logic        s_axis_tuser,   // brace_as_token
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [1:0] kind, [9:2] value, [25:10] line_number
  output logic        m_axis_tlast    // last
);

  logic    q_ready;
  logic    push;
  bundle_t push_data;
  logic    q_valid;
  logic    q_pop;
  bundle_t q_head;
  res_t    out_res;

  // Scanner: classifies each byte and builds its result bundle.
  bqwt_front #(
    .NEST_BITS (NEST_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .byte_in        (s_axis_tdata),
    .end_of_input   (s_axis_tlast),
    .brace_as_token (s_axis_tuser),
    .q_ready        (q_ready),
    .in_ready       (s_axis_tready),
    .push           (push),
    .bundle         (push_data)
  );

  // Decouples the scanner from downstream back-pressure.
  bqwt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Serializes each bundle onto the output stream.
  bqwt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_res.line, out_res.value, out_res.kind};

endmodule
